@@ rtl/irafmt_pkg.sv @@
// shared types, codes and the digit table of the integer to ascii formatter
`default_nettype none
package irafmt_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int VALUE_W       = 64;
    localparam int WIDTH_W       = 7;
    localparam int CHAR_W        = 7;
    localparam int NUM_DIGITS    = 22;
    localparam int DIG_CNT_W     = 5;
    localparam int BCD_DIGITS    = 20;
    localparam int ITER_W        = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] CONV_OCT = 2'd0;
    localparam logic [1:0] CONV_SDEC = 2'd1;
    localparam logic [1:0] CONV_UDEC = 2'd2;
    localparam logic [1:0] CONV_HEX = 2'd3;

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        logic                 neg;
        logic                 zpad;
        logic [WIDTH_W-1:0]   pad_cnt;
        logic [DIG_CNT_W-1:0] dig_cnt;
        digits_t              digits;
    } q_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'hA: c = 7'h41;
            4'hB: c = 7'h42;
            4'hC: c = 7'h43;
            4'hD: c = 7'h44;
            4'hE: c = 7'h45;
            4'hF: c = 7'h46;
            default: c = 7'h30;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/irafmt_front.sv @@
// front end: takes a number, splits it into digits and works out sign and padding
`default_nettype none
module irafmt_front #(
    parameter int MAX_WIDTH = irafmt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [irafmt_pkg::VALUE_W-1:0] in_value,
    input  wire logic [1:0]                   in_conv,
    input  wire logic [irafmt_pkg::WIDTH_W-1:0] in_width,
    input  wire logic                         in_zpad,
    output logic                              push,
    output irafmt_pkg::q_entry_t              push_entry,
    input  wire logic                         q_full
);
    import irafmt_pkg::*;

    localparam logic [WIDTH_W-1:0] MAXW = WIDTH_W'(MAX_WIDTH);

    front_state_t         state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    digits_t              dig_reg, dig_next;
    logic                 neg_reg, neg_next;
    logic                 zpad_reg, zpad_next;
    logic [WIDTH_W-1:0]   w_reg, w_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;

    logic                 accept;
    logic                 in_neg;
    logic [VALUE_W-1:0]   in_mag;
    logic [VALUE_W+1:0]   oct_src;
    digits_t              direct_digits;
    logic [BCD_DIGITS*4-1:0] bcd_adj;
    logic [DIG_CNT_W-1:0] cnt;
    logic [WIDTH_W-1:0]   w_eff;

    assign accept = in_valid && in_ready;
    assign in_neg = (in_conv == CONV_SDEC) && in_value[VALUE_W-1];
    assign in_mag = in_neg ? (VALUE_W'(0) - in_value) : in_value;
    assign oct_src = {2'b00, in_mag};

    always_comb
    begin
        direct_digits = '0;
        if (in_conv == CONV_HEX)
        begin
            for (int i = 0; i < 16; i++)
                direct_digits[i] = in_mag[4*i +: 4];
        end
        else
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
                direct_digits[i] = {1'b0, oct_src[3*i +: 3]};
        end
    end

    // add-3 adjust of every bcd digit before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
            bcd_adj[4*i +: 4] = (dig_reg[i] >= 4'd5) ? (dig_reg[i] + 4'd3) : dig_reg[i];
    end

    always_comb
    begin
        cnt = DIG_CNT_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++)
            if (dig_reg[i] != 4'd0)
                cnt = DIG_CNT_W'(i + 1);
    end

    assign w_eff = (neg_reg && (w_reg != '0)) ? (w_reg - WIDTH_W'(1)) : w_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = ((in_conv == CONV_SDEC) || (in_conv == CONV_UDEC))
                                 ? F_CONV : F_PUSH;
            end
            F_CONV:
            begin
                if (iter_reg == '0)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready   = (state_reg == F_IDLE);
        push       = (state_reg == F_PUSH) && !q_full;
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        zpad_next  = zpad_reg;
        w_next     = w_reg;
        iter_next  = iter_reg;

        push_entry.neg     = neg_reg;
        push_entry.zpad    = zpad_reg;
        push_entry.dig_cnt = cnt;
        push_entry.digits  = dig_reg;
        push_entry.pad_cnt = (w_eff > WIDTH_W'(cnt)) ? (w_eff - WIDTH_W'(cnt)) : '0;

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    mag_next  = in_mag;
                    neg_next  = in_neg;
                    zpad_next = in_zpad;
                    w_next    = (in_width > MAXW) ? MAXW : in_width;
                    iter_next = '1;
                    if ((in_conv == CONV_SDEC) || (in_conv == CONV_UDEC))
                        dig_next = '0;
                    else
                        dig_next = direct_digits;
                end
            end
            F_CONV:
            begin
                dig_next = {8'b0, bcd_adj[BCD_DIGITS*4-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                iter_next = iter_reg - ITER_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        neg_reg  <= neg_next;
        zpad_reg <= zpad_next;
        w_reg    <= w_next;
        iter_reg <= iter_next;
    end

endmodule
`default_nettype wire

@@ rtl/irafmt_queue.sv @@
// two-entry queue of converted numbers between front and back end
`default_nettype none
module irafmt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire irafmt_pkg::q_entry_t push_entry,
    output logic               full,
    input  wire logic          pop,
    output irafmt_pkg::q_entry_t head,
    output logic               empty
);
    import irafmt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (PTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

@@ rtl/irafmt_back.sv @@
// back end: emits sign, padding and digits one character per beat
`default_nettype none
module irafmt_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire irafmt_pkg::q_entry_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [irafmt_pkg::CHAR_W-1:0] out_char,
    output logic               out_last
);
    import irafmt_pkg::*;

    back_state_t          state_reg, state_next;
    logic                 neg_reg, neg_next;
    logic                 zpad_reg, zpad_next;
    logic [WIDTH_W-1:0]   pad_reg, pad_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    digits_t              dig_reg, dig_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 step;
    logic                 final_digit;
    logic [DIG_CNT_W-1:0] idx;

    assign step        = (state_reg == B_RUN) && (!valid_reg || out_ready);
    assign idx         = cnt_reg - DIG_CNT_W'(1);
    assign final_digit = !neg_reg && (pad_reg == '0) && (cnt_reg == DIG_CNT_W'(1));

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = B_RUN;
            end
            B_RUN:
            begin
                if (step && final_digit)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop        = (state_reg == B_IDLE) && !empty;
        neg_next   = neg_reg;
        zpad_next  = zpad_reg;
        pad_next   = pad_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    neg_next  = head.neg;
                    zpad_next = head.zpad;
                    pad_next  = head.pad_cnt;
                    cnt_next  = head.dig_cnt;
                    dig_next  = head.digits;
                end
            end
            B_RUN:
            begin
                if (step)
                begin
                    valid_next = 1'b1;
                    last_next  = final_digit;
                    if (neg_reg)
                    begin
                        char_next = CH_MINUS;
                        neg_next  = 1'b0;
                    end
                    else if (pad_reg != '0)
                    begin
                        char_next = zpad_reg ? CH_ZERO : CH_SPACE;
                        pad_next  = pad_reg - WIDTH_W'(1);
                    end
                    else
                    begin
                        char_next = hex_char(dig_reg[idx]);
                        cnt_next  = idx;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        zpad_reg <= zpad_next;
        pad_reg  <= pad_next;
        cnt_reg  <= cnt_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

@@ rtl/integer_to_radix_ascii_formatter_unit.sv @@
// Integer to ASCII formatter (octal, signed/unsigned decimal, uppercase hex).
// Input stream: one beat per number: value, minimum field width and pad
// flag in s_tdata, conversion kind in s_tuser. Output stream: one beat per
// character, most significant first, with m_tlast on the final character.
// A negative signed value gives a leading '-' that counts toward the width;
// pad characters (space or '0') go between the sign and the digits.
// The front end takes a number and converts it: octal and hex split directly,
// decimal runs a shift-and-add-3 loop over the value bits, most significant
// first. The result goes into a two-entry queue, and the back end emits one
// character per cycle from it while the receiver is ready.
// The front end takes no new number while it converts or pushes one, but it
// can take the next number while the back end is still emitting the last.
// When the receiver stalls, the back end holds its character and the queue
// fills; the front end then stops taking beats until a slot frees up.
// Reset clears the queue and both control machines; no stream is open.
`default_nettype none
module integer_to_radix_ascii_formatter_unit #(
    parameter int MAX_WIDTH = irafmt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // value[63:0], width[70:64], zero_pad[71]
    input  wire logic [1:0]  s_tuser,   // conversion[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // character[6:0], zero[7]
    output logic             m_tlast
);
    import irafmt_pkg::*;

    logic        push;
    q_entry_t    push_entry;
    logic        q_full;
    logic        pop;
    q_entry_t    head;
    logic        q_empty;
    logic [CHAR_W-1:0] out_char;

    irafmt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata[63:0]),
        .in_conv    (s_tuser),
        .in_width   (s_tdata[70:64]),
        .in_zpad    (s_tdata[71]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    irafmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    irafmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

@@ bench/integer_to_radix_ascii_formatter_unit_tb.sv @@
// self-checking bench for the integer to radix ascii formatter stream unit
`timescale 1ns / 100ps
module integer_to_radix_ascii_formatter_unit_tb;

    import irafmt_pkg::*;

    localparam int               FIELD_MAX   = MAX_WIDTH_DEF;
    localparam logic [CHAR_W-1:0] ALPHA_BASE = 7'h37;   // 'A' minus ten
    localparam int               RANDOM_NUMS = 250;
    localparam int               DRAIN_CYCLES = 100;
    localparam longint           CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_beat_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [1:0]         conv;
        logic [WIDTH_W-1:0] wid;
        logic               zpad;
        string              text;   // empty when the predictor supplies the result
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    char_beat_t  pending_chars [$];
    string       row_texts [$];
    stim_row_t   directed_rows [$];
    int          fault_count;
    longint      cycle_count;
    logic        no_gaps;

    integer_to_radix_ascii_formatter_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 8));
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    function automatic void add_row(input logic [VALUE_W-1:0] value, input logic [1:0] conv,
                                    input logic [WIDTH_W-1:0] wid, input logic zpad,
                                    input string text);
        stim_row_t row;
        row.value = value;
        row.conv  = conv;
        row.wid   = wid;
        row.zpad  = zpad;
        row.text  = text;
        directed_rows.push_back(row);
    endfunction

    function automatic void expect_text(input string text);
        char_beat_t beat;
        byte        ch;
        for (int i = 0; i < text.len(); i++)
        begin
            ch        = text[i];
            beat.code = ch[CHAR_W-1:0];
            beat.last = (i == text.len() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // expected character run of one number, appended to the pending store
    function automatic void predict_chars(input logic [VALUE_W-1:0] value, input logic [1:0] conv,
                                          input logic [WIDTH_W-1:0] wid, input logic zpad);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [3:0]         digs [$];
        logic [CHAR_W-1:0]  run_chars [$];
        char_beat_t         beat;
        int                 field;
        mag   = value;
        field = (wid > FIELD_MAX) ? FIELD_MAX : int'(wid);
        case (conv)
            CONV_OCT: radix = 64'd8;
            CONV_HEX: radix = 64'd16;
            default:  radix = 64'd10;
        endcase
        if (conv == CONV_SDEC && value[VALUE_W-1])
        begin
            run_chars.push_back(CH_MINUS);
            mag = -value;
            if (field > 0)
                field--;
        end
        do
        begin
            digs.push_front(4'(mag % radix));
            mag = mag / radix;
        end
        while (mag != 0);
        while (field > digs.size())
        begin
            run_chars.push_back(zpad ? CH_ZERO : CH_SPACE);
            field--;
        end
        foreach (digs[i])
            run_chars.push_back((digs[i] < 4'd10) ? CH_ZERO + 7'(digs[i])
                                                  : ALPHA_BASE + 7'(digs[i]));
        foreach (run_chars[i])
        begin
            beat.code = run_chars[i];
            beat.last = (i == run_chars.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // drive one number, starting and ending at a falling edge
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic [1:0] conv,
                               input logic [WIDTH_W-1:0] wid, input logic zpad,
                               input string text);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_texts.push_back(text);
        s_tvalid <= 1'b1;
        s_tdata  <= {zpad, wid, value};
        s_tuser  <= conv;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // input acceptance and output checking, both sampled at the rising edge
    always @(posedge clk)
    begin
        char_beat_t want;
        string      text;
        if (rst_n && s_tvalid && s_tready)
        begin
            text = row_texts.pop_front();
            if (text.len() != 0)
                expect_text(text);
            else
                predict_chars(s_tdata[63:0], s_tuser, s_tdata[70:64], s_tdata[71]);
        end
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_chars.size() == 0)
                note_fault($sformatf("unexpected beat: tdata=%h tlast=%b", m_tdata, m_tlast));
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last)
                    note_fault($sformatf("char mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                         {1'b0, want.code}, want.last, m_tdata, m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("integer_to_radix_ascii_formatter_unit_tb: errors");
            $finish;
        end
    end

    // receiver: random stall before every beat
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_gap();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready));
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] rval;
        logic [WIDTH_W-1:0] rwid;
        int                 kind;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CONV_OCT;
        rst_n       = 1'b0;
        no_gaps     = 1'b0;
        fault_count = 0;
        cycle_count = 0;

        add_row(64'd0, CONV_HEX, 7'd0, 1'b0, "0");
        add_row(64'd0, CONV_OCT, 7'd5, 1'b1, "00000");
        add_row(64'd0, CONV_SDEC, 7'd3, 1'b0, "  0");
        add_row('1, CONV_SDEC, 7'd0, 1'b0, "-1");
        add_row(64'h8000_0000_0000_0000, CONV_SDEC, 7'd0, 1'b0, "-9223372036854775808");
        add_row(64'h7FFF_FFFF_FFFF_FFFF, CONV_SDEC, 7'd0, 1'b0, "9223372036854775807");
        add_row('1, CONV_UDEC, 7'd0, 1'b0, "18446744073709551615");
        add_row('1, CONV_OCT, 7'd0, 1'b0, "1777777777777777777777");
        add_row('1, CONV_HEX, 7'd0, 1'b0, "FFFFFFFFFFFFFFFF");
        add_row(-64'sd5, CONV_SDEC, 7'd4, 1'b1, "-005");
        add_row(-64'sd5, CONV_SDEC, 7'd4, 1'b0, "-  5");
        add_row(-64'sd5, CONV_SDEC, 7'd1, 1'b0, "-5");
        add_row(-64'sd7, CONV_SDEC, 7'd0, 1'b1, "-7");
        add_row(64'h8000_0000_0000_0000, CONV_UDEC, 7'd0, 1'b0, "9223372036854775808");
        add_row(64'hAB_CDEF, CONV_HEX, 7'd2, 1'b1, "ABCDEF");
        add_row(64'd8, CONV_OCT, 7'd0, 1'b0, "10");
        add_row(64'd1, CONV_SDEC, 7'd1, 1'b1, "1");
        add_row(64'd255, CONV_HEX, 7'd127, 1'b0, "");
        add_row(64'd255, CONV_OCT, 7'd65, 1'b1, "");
        add_row(64'd42, CONV_UDEC, 7'd64, 1'b1, "");
        add_row(64'h8000_0000_0000_0000, CONV_HEX, 7'd20, 1'b1, "");
        add_row(64'h0123_4567_89AB_CDEF, CONV_HEX, 7'd64, 1'b0, "");
        add_row(-64'sd123456789, CONV_SDEC, 7'd127, 1'b1, "");
        add_row(64'd999, CONV_UDEC, 7'd63, 1'b0, "");

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_number(directed_rows[i].value, directed_rows[i].conv, directed_rows[i].wid,
                        directed_rows[i].zpad, directed_rows[i].text);

        for (int n = 0; n < RANDOM_NUMS; n++)
        begin
            // a stretch with both sides running flat out
            no_gaps = (n >= 80 && n < 140);
            kind = $urandom_range(0, 5);
            case (kind)
                0: rval = {$urandom, $urandom};
                1: rval = 64'($urandom_range(0, 1000));
                2: rval = -64'($urandom_range(1, 100000));
                3: rval = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
                4: rval = '0;
                default: rval = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            if ($urandom_range(0, 7) == 0)
                rwid = 7'($urandom_range(0, 127));
            else
                rwid = 7'($urandom_range(0, 30));
            send_number(rval, 2'($urandom_range(0, 3)), rwid, 1'($urandom_range(0, 1)), "");
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("integer_to_radix_ascii_formatter_unit_tb: clean");
        else
            $display("integer_to_radix_ascii_formatter_unit_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/irafmt_pkg.sv
rtl/irafmt_front.sv
rtl/irafmt_queue.sv
rtl/irafmt_back.sv
rtl/integer_to_radix_ascii_formatter_unit.sv
bench/integer_to_radix_ascii_formatter_unit_tb.sv
